@@ rtl/ccbp_pkg.sv @@
// ----------------------------------------------------------------------------
// CRC codeword bit packer package
// Shared types and fixed constants for the encoder, the packer and the testbench.
// ----------------------------------------------------------------------------
package ccbp_pkg;

    localparam int GEN_POLY_W = 16;
    localparam int GEN_LEN_W  = 5;
    localparam int PAD_W      = 3;
    localparam int RES_W      = 7;
    localparam int RES_CNT_W  = 3;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [GEN_POLY_W-1:0] GEN_POLY_RST = 16'd11;
    localparam logic [GEN_LEN_W-1:0]  GEN_LEN_RST  = 5'd4;
    localparam logic [GEN_LEN_W-1:0]  GEN_LEN_MIN  = 5'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GEN_POLY  = 2'd0,
        CFG_GEN_LEN   = 2'd1,
        CFG_WORD_MODE = 2'd2,
        CFG_PAD_BITS  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [GEN_POLY_W-1:0] gen_poly;
        logic [GEN_LEN_W-1:0]  gen_len;
        logic                  word_mode;
        logic [PAD_W-1:0]      pad_bits;
    } cfg_t;

    typedef struct packed {
        logic [RES_W-1:0]     residue_bits;
        logic [RES_CNT_W-1:0] residue_count;
        logic                 header_sent;
    } pack_state_t;

endpackage

@@ rtl/ccbp_encode.sv @@
// ----------------------------------------------------------------------------
// CRC codeword encoder and bit packer
// Forms the codeword or codewords of one byte, appends them to the leftover
// bits and lays out the whole bytes that are ready, header byte first at the start of a stream.
// ----------------------------------------------------------------------------
module ccbp_encode #(
    parameter int MAX_GEN_LEN = 16,
    localparam int LEN_LIM = (MAX_GEN_LEN < 16) ? MAX_GEN_LEN : 16,
    localparam int RW      = LEN_LIM - 1,
    localparam int CW_W    = 2 * (4 + RW),
    localparam int ACC_W   = CW_W + ccbp_pkg::RES_W,
    localparam int PAY_N   = ACC_W / 8,
    localparam int PAY_W   = PAY_N * 8,
    localparam int EMIT_N  = PAY_N + 1,
    localparam int EMIT_W  = EMIT_N * 8,
    localparam int CNT_W   = $clog2(EMIT_N + 1)
)
(
    input  logic [7:0]            data_byte,
    input  ccbp_pkg::cfg_t        cfg,
    input  ccbp_pkg::pack_state_t state,
    output logic [EMIT_W-1:0]     emit_bytes,
    output logic [CNT_W-1:0]      emit_count,
    output ccbp_pkg::pack_state_t state_next
);

    localparam int TW = $clog2(ACC_W + 1);

    logic [ccbp_pkg::GEN_LEN_W-1:0] len_eff;
    logic [ccbp_pkg::GEN_LEN_W-1:0] len_m1;
    logic [RW-1:0]                  rmask;
    logic [RW-1:0]                  tmask;
    logic [RW-1:0]                  gpoly;
    logic [RW-1:0]                  rem8;
    logic [RW-1:0]                  rem_hi;
    logic [RW-1:0]                  rem_lo;
    logic [CW_W-1:0]                cw8;
    logic [CW_W-1:0]                cw_hi;
    logic [CW_W-1:0]                cw_lo;
    logic [CW_W-1:0]                cw4;
    logic [CW_W-1:0]                cw;
    logic [TW-1:0]                  n4;
    logic [TW-1:0]                  n_bits;
    logic [ccbp_pkg::RES_W-1:0]     pre_bits;
    logic [ccbp_pkg::RES_CNT_W-1:0] pre_cnt;
    logic [ACC_W-1:0]               acc;
    logic [ACC_W-1:0]               acc_left;
    logic [TW-1:0]                  total;
    logic [PAY_W-1:0]               payload;

    function automatic logic [RW-1:0] crc_rem(
        input logic [7:0]    bits,
        input logic          nibble,
        input logic [RW-1:0] msk,
        input logic [RW-1:0] top,
        input logic [RW-1:0] g
    );
        logic [RW-1:0] r;
        logic          fb;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (!nibble || i < 4)
            begin
                fb = bits[7-i] ^ ((r & top) != '0);
                r  = ((r << 1) & msk) ^ (fb ? g : '0);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        if (cfg.gen_len > ccbp_pkg::GEN_LEN_W'(LEN_LIM))
        begin
            len_eff = ccbp_pkg::GEN_LEN_W'(LEN_LIM);
        end
        else if (cfg.gen_len < ccbp_pkg::GEN_LEN_MIN)
        begin
            len_eff = ccbp_pkg::GEN_LEN_MIN;
        end
        else
        begin
            len_eff = cfg.gen_len;
        end
    end

    assign len_m1 = len_eff - ccbp_pkg::GEN_LEN_W'(1);
    assign rmask  = ~({RW{1'b1}} << len_m1);
    assign tmask  = rmask ^ (rmask >> 1);
    assign gpoly  = cfg.gen_poly[RW-1:0] & rmask;

    assign rem8   = crc_rem(data_byte, 1'b0, rmask, tmask, gpoly);
    assign rem_hi = crc_rem({data_byte[7:4], 4'b0000}, 1'b1, rmask, tmask, gpoly);
    assign rem_lo = crc_rem({data_byte[3:0], 4'b0000}, 1'b1, rmask, tmask, gpoly);

    assign cw8   = (CW_W'(data_byte) << len_m1) | CW_W'(rem8);
    assign cw_hi = (CW_W'(data_byte[7:4]) << len_m1) | CW_W'(rem_hi);
    assign cw_lo = (CW_W'(data_byte[3:0]) << len_m1) | CW_W'(rem_lo);
    assign n4    = TW'(len_eff) + TW'(3);
    assign cw4   = (cw_hi << n4) | cw_lo;

    assign cw     = cfg.word_mode ? cw4 : cw8;
    assign n_bits = cfg.word_mode ? (n4 + n4) : (TW'(len_eff) + TW'(7));

    assign pre_bits = state.header_sent ? state.residue_bits : '0;
    assign pre_cnt  = state.header_sent ? state.residue_count : cfg.pad_bits;

    assign acc      = (ACC_W'(pre_bits) << n_bits) | ACC_W'(cw);
    assign total    = TW'(pre_cnt) + n_bits;
    assign acc_left = acc << (TW'(ACC_W) - total);
    assign payload  = acc_left[ACC_W-1 -: PAY_W];

    assign emit_bytes = state.header_sent ? {payload, 8'h00}
                                          : {8'(cfg.pad_bits), payload};
    assign emit_count = CNT_W'(total[TW-1:3]) + CNT_W'(!state.header_sent);

    assign state_next.residue_bits  = acc[ccbp_pkg::RES_W-1:0]
                                      & ~({ccbp_pkg::RES_W{1'b1}} << total[2:0]);
    assign state_next.residue_count = total[2:0];
    assign state_next.header_sent   = 1'b1;

endmodule

@@ rtl/crc_codeword_bit_packer_unit.sv @@
// ----------------------------------------------------------------------------
// CRC codeword bit packer
// Streams input bytes through a programmable CRC encoder and packs the
// codewords, with a header byte and padding per stream, into output bytes.
// ----------------------------------------------------------------------------
// An input byte is held in the input register, then encoded into the output register
// once that is free; it causes 1 to 6 output bytes, and the next input byte can be taken
// meanwhile. The output register emits one byte a cycle while m_tready is high and reloads
// with no gap. Reset clears the configuration to its defaults and empties both registers.
module crc_codeword_bit_packer_unit #(
    parameter int MAX_GEN_LEN = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    // s_tdata: data_byte[7:0]
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    // m_tdata: out_byte[7:0]
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int LEN_LIM = (MAX_GEN_LEN < 16) ? MAX_GEN_LEN : 16;
    localparam int PAY_N   = (2 * (4 + LEN_LIM - 1) + ccbp_pkg::RES_W) / 8;
    localparam int EMIT_N  = PAY_N + 1;
    localparam int EMIT_W  = EMIT_N * 8;
    localparam int CNT_W   = $clog2(EMIT_N + 1);

    ccbp_pkg::cfg_t        cfg_reg;
    ccbp_pkg::pack_state_t state_reg;
    ccbp_pkg::pack_state_t state_next;
    ccbp_pkg::pack_state_t enc_state;

    logic              a_valid_reg;
    logic              a_valid_next;
    logic [7:0]        a_data_reg;
    logic              a_last_reg;
    logic [EMIT_W-1:0] emit_reg;
    logic [EMIT_W-1:0] emit_next;
    logic [CNT_W-1:0]  emit_cnt_reg;
    logic [CNT_W-1:0]  emit_cnt_next;
    logic [EMIT_W-1:0] enc_bytes;
    logic [CNT_W-1:0]  enc_count;
    logic              s_fire;
    logic              m_fire;
    logic              b_free;
    logic              a_load;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gen_poly  <= ccbp_pkg::GEN_POLY_RST;
            cfg_reg.gen_len   <= ccbp_pkg::GEN_LEN_RST;
            cfg_reg.word_mode <= 1'b0;
            cfg_reg.pad_bits  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (ccbp_pkg::cfg_index_t'(cfg_index))
                ccbp_pkg::CFG_GEN_POLY:  cfg_reg.gen_poly  <= cfg_data;
                ccbp_pkg::CFG_GEN_LEN:   cfg_reg.gen_len   <= cfg_data[ccbp_pkg::GEN_LEN_W-1:0];
                ccbp_pkg::CFG_WORD_MODE: cfg_reg.word_mode <= cfg_data[0];
                ccbp_pkg::CFG_PAD_BITS:  cfg_reg.pad_bits  <= cfg_data[ccbp_pkg::PAD_W-1:0];
                default:                 cfg_reg.pad_bits  <= cfg_reg.pad_bits;
            endcase
        end
    end

    ccbp_encode #(
        .MAX_GEN_LEN (MAX_GEN_LEN)
    ) u_encode (
        .data_byte  (a_data_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .emit_bytes (enc_bytes),
        .emit_count (enc_count),
        .state_next (enc_state)
    );

    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;
    assign b_free   = (emit_cnt_reg == '0) || ((emit_cnt_reg == CNT_W'(1)) && m_tready);
    assign a_load   = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || a_load;

    assign m_tvalid = (emit_cnt_reg != '0);
    assign m_tdata  = emit_reg[EMIT_W-1 -: 8];
    assign m_tlast  = (emit_cnt_reg == CNT_W'(1));

    always_comb
    begin
        a_valid_next  = a_valid_reg;
        emit_next     = emit_reg;
        emit_cnt_next = emit_cnt_reg;
        state_next    = state_reg;
        if (s_fire)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_load)
        begin
            a_valid_next = 1'b0;
        end
        if (a_load)
        begin
            emit_next     = enc_bytes;
            emit_cnt_next = enc_count;
            if (a_last_reg)
            begin
                state_next = '0;
            end
            else
            begin
                state_next = enc_state;
            end
        end
        else if (m_fire)
        begin
            emit_next     = emit_reg << 8;
            emit_cnt_next = emit_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            emit_cnt_reg <= '0;
            state_reg    <= '0;
        end
        else
        begin
            a_valid_reg  <= a_valid_next;
            emit_cnt_reg <= emit_cnt_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            a_data_reg <= s_tdata;
            a_last_reg <= s_tlast;
        end
        emit_reg <= emit_next;
    end

endmodule

@@ rtl/ccbp_checker.sv @@
// ----------------------------------------------------------------------------
// CRC codeword bit packer port checker
// Watches the ports of the packer over time and reports broken behaviour.
// ----------------------------------------------------------------------------
module ccbp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // A stalled output transfer keeps its byte and its end mark.
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // Output runs only end with a transfer that carries tlast.
    a_run_end : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tlast && m_tready))
        else $error("output run ended without tlast");

    // With the output register empty the input side is never held off.
    a_in_ready : assert property (@(posedge clk)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output empty");

    // Configuration writes are always taken.
    a_cfg_ready : assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // Leaving reset, no output byte is on offer.
    a_reset_empty : assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid straight after reset");

endmodule

bind crc_codeword_bit_packer_unit ccbp_checker u_ccbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

@@ sim/crc_codeword_bit_packer_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRC codeword bit packer testbench
// Streams bytes into the packer under several generator, word mode and
// padding settings. A local predictor forms the header, padding and codeword
// bits of every accepted byte and queues the packed bytes it should produce;
// each output transfer is compared with the oldest queued byte. The input
// side sends in bursts with random gaps and the output side stalls on a
// rotating pattern, at random, or not at all.
// ----------------------------------------------------------------------------
module crc_codeword_bit_packer_unit_tb;

    localparam int MAX_GEN_LEN = 16;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int RANDOM_PHASES = 8;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN
    } ready_mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } packed_byte_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    ccbp_pkg::cfg_t        model_cfg;
    ccbp_pkg::pack_state_t model_state;
    packed_byte_t          pending_bytes[$];
    int                    fail_count = 0;
    int                    burst_left = 0;
    ready_mode_t           ready_mode = READY_ALWAYS;
    logic [15:0]           ready_pattern = 16'hFFFF;

    crc_codeword_bit_packer_unit #(
        .MAX_GEN_LEN(MAX_GEN_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
    begin
        case (ready_mode)
            READY_ALWAYS:
                m_tready <= 1'b1;
            READY_RANDOM:
                m_tready <= ($urandom_range(0, 99) < 65);
            default:
            begin
                m_tready <= ready_pattern[0];
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            end
        endcase
    end

    function automatic logic [31:0] crc_codeword(input logic [7:0] word,
                                                 input int unsigned width,
                                                 input int unsigned glen);
        logic [31:0] gen;
        logic [31:0] rem;
        int unsigned top;
        gen = 32'(model_cfg.gen_poly) & ((32'd1 << glen) - 32'd1);
        rem = 32'(word) << (glen - 1);
        for (int i = 0; i < width; i++)
        begin
            top = width + glen - 2 - i;
            if (rem[top])
                rem = rem ^ (gen << (top - (glen - 1)));
        end
        return (32'(word) << (glen - 1)) | (rem & ((32'd1 << (glen - 1)) - 32'd1));
    endfunction

    function automatic void predict_packed_bytes(input logic [7:0] data, input logic last);
        logic [63:0]  acc;
        int unsigned  cnt;
        int unsigned  glen;
        int unsigned  cw_width;
        logic [7:0]   bytes_out[6];
        int           k;
        packed_byte_t item;
        k = 0;
        glen = model_cfg.gen_len;
        if (glen > MAX_GEN_LEN)
            glen = MAX_GEN_LEN;
        if (glen > 16)
            glen = 16;
        if (glen < 2)
            glen = 2;
        acc = 64'(model_state.residue_bits);
        cnt = model_state.residue_count;
        if (!model_state.header_sent)
        begin
            bytes_out[0] = 8'(model_cfg.pad_bits);
            k = 1;
            model_state.header_sent = 1'b1;
            acc = '0;
            cnt = model_cfg.pad_bits;
        end
        if (model_cfg.word_mode)
        begin
            cw_width = 4 + glen - 1;
            acc = (acc << cw_width) | 64'(crc_codeword({4'b0, data[7:4]}, 4, glen));
            acc = (acc << cw_width) | 64'(crc_codeword({4'b0, data[3:0]}, 4, glen));
            cnt = cnt + 2 * cw_width;
        end
        else
        begin
            cw_width = 8 + glen - 1;
            acc = (acc << cw_width) | 64'(crc_codeword(data, 8, glen));
            cnt = cnt + cw_width;
        end
        while (cnt >= 8)
        begin
            cnt = cnt - 8;
            bytes_out[k] = 8'(acc >> cnt);
            acc = acc & ((64'd1 << cnt) - 64'd1);
            k++;
        end
        if (last)
            model_state = '0;
        else
        begin
            model_state.residue_bits = acc[6:0];
            model_state.residue_count = cnt[2:0];
        end
        for (int j = 0; j < k; j++)
        begin
            item.out_byte = bytes_out[j];
            item.run_last = (j == k - 1);
            pending_bytes.push_back(item);
        end
    endfunction

    always @(posedge clk)
    begin : byte_checker
        packed_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected output transfer: out_byte %0h run_last %0b",
                       m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.run_last)
                begin
                    $error("run_last: expected %0b, got %0b", want.run_last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_packed_bytes(data, last);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic settle_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_cfg_reg(input ccbp_pkg::cfg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            ccbp_pkg::CFG_GEN_POLY:  model_cfg.gen_poly = value;
            ccbp_pkg::CFG_GEN_LEN:   model_cfg.gen_len = value[4:0];
            ccbp_pkg::CFG_WORD_MODE: model_cfg.word_mode = value[0];
            ccbp_pkg::CFG_PAD_BITS:  model_cfg.pad_bits = value[2:0];
            default:                 ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [15:0] poly, input logic [15:0] len,
                                 input logic [15:0] mode, input logic [15:0] pad);
        settle_idle();
        write_cfg_reg(ccbp_pkg::CFG_GEN_POLY, poly);
        write_cfg_reg(ccbp_pkg::CFG_GEN_LEN, len);
        write_cfg_reg(ccbp_pkg::CFG_WORD_MODE, mode);
        write_cfg_reg(ccbp_pkg::CFG_PAD_BITS, pad);
    endtask

    task automatic test_reset_defaults();
        ready_mode = READY_ALWAYS;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
    endtask

    task automatic test_word_mode_and_padding();
        ready_mode = READY_RANDOM;
        load_settings(16'hFFFF, 16'd16, 16'd1, 16'd7);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b1);
        load_settings(16'h0003, 16'd2, 16'hFFFE, 16'd0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h0F, 1'b1);
    endtask

    task automatic test_generator_corners();
        ready_mode = READY_PATTERN;
        ready_pattern = 16'hB3C5;
        load_settings(16'h1234, 16'd0, 16'd0, 16'd3);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b1);
        load_settings(16'hFFFF, 16'hFFFF, 16'd1, 16'd5);
        send_byte(8'h96, 1'b0);
        send_byte(8'h69, 1'b1);
        load_settings(16'h0005, 16'd1, 16'd0, 16'd1);
        send_byte(8'h7E, 1'b1);
        load_settings(16'hABCD, 16'd17, 16'd0, 16'd2);
        send_byte(8'h81, 1'b1);
        // The generator here has no leading one within its eight bits.
        load_settings(16'h0017, 16'd8, 16'd0, 16'd6);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b1);
        load_settings(16'h0000, 16'd9, 16'd1, 16'd4);
        send_byte(8'hE7, 1'b1);
    endtask

    task automatic test_random_streams();
        logic [15:0] len;
        int          sent;
        int          stream_len;
        logic        last;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       len = 16'd2;
                1:       len = 16'd16;
                2:       len = 16'($urandom_range(0, 31)) | 16'($urandom) & 16'hFFE0;
                default: len = 16'($urandom_range(2, 16));
            endcase
            if (phase == 0)
                load_settings(16'($urandom), len, 16'd0, 16'd0);
            else if (phase == 1)
                load_settings(16'($urandom), len, 16'd1, 16'd7);
            else
                load_settings(16'($urandom), len, 16'($urandom), 16'($urandom));
            ready_mode = ready_mode_t'(phase % 3);
            ready_pattern = 16'($urandom) | 16'h0001;
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                stream_len = $urandom_range(1, 12);
                for (int j = 0; j < stream_len && sent < ITEMS_PER_PHASE; j++)
                begin
                    last = (j == stream_len - 1) || ($urandom_range(0, 19) == 0);
                    send_byte(8'($urandom), last);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        model_cfg.gen_poly = ccbp_pkg::GEN_POLY_RST;
        model_cfg.gen_len = ccbp_pkg::GEN_LEN_RST;
        model_cfg.word_mode = 1'b0;
        model_cfg.pad_bits = '0;
        model_state = '0;
        burst_left = $urandom_range(0, 6);
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_word_mode_and_padding();
        test_generator_corners();
        test_random_streams();
        settle_idle();
        if (fail_count == 0)
            $display("crc_codeword_bit_packer_unit regression: pass");
        else
            $display("crc_codeword_bit_packer_unit regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("crc_codeword_bit_packer_unit regression: fail");
        $finish;
    end

endmodule
